### design/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsvrgb_pkg;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  // Stage load enables for the per-channel scaling pipe.
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  localparam logic [14:0] HUE_FULL     = 15'd23040;
  localparam logic [11:0] SECTOR_STEPS = 12'd3840;
  localparam logic [7:0]  FRAC_ONE     = 8'd255;
  localparam logic [9:0]  CHAN_MAX     = 10'd255;

  // Sector numbers (60 degree slices of the hue circle).
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED  = 3'd5;

  // Channel divisor 255*3840 and its scaled reciprocal.
  localparam int unsigned    DIV_VAL     = 979200;
  localparam int unsigned    RECIP_SHIFT = 48;
  localparam logic [28:0]    DIVISOR     = 29'(DIV_VAL);
  localparam longint unsigned RECIP_VAL  = (64'd1 << RECIP_SHIFT) / DIV_VAL;
  localparam logic [28:0]    RECIP       = 29'(RECIP_VAL);

endpackage

### design/hsvrgb_chan.sv
// One color channel: scale by brightness, then divide by 255*3840 rounding up.
module hsvrgb_chan
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  adv_t        adv,
  input  logic [7:0]  brightness,
  input  logic [19:0] mix,
  output logic [7:0]  level
);

  logic [27:0] num3;
  logic [27:0] num4;
  logic [8:0]  qest4;
  logic [56:0] scaled;
  logic [28:0] back;
  logic [28:0] rem0;
  logic [28:0] rem1;
  logic [9:0]  q1;
  logic [9:0]  q2;

  // Reciprocal estimate is the true floor or one below it.
  assign scaled = 57'(num3) * 57'(RECIP);

  always_comb begin
    back = 29'(qest4) * DIVISOR;
    rem0 = 29'(num4) - back;
    if (rem0 >= DIVISOR) begin
      q1   = 10'(qest4) + 10'd1;
      rem1 = rem0 - DIVISOR;
    end else begin
      q1   = 10'(qest4);
      rem1 = rem0;
    end
    q2 = q1 + ((rem1 != 29'd0) ? 10'd1 : 10'd0);
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      num3 <= 28'(brightness) * 28'(mix);
    end
    if (adv.s4) begin
      num4  <= num3;
      qest4 <= scaled[56:48];
    end
    if (adv.s5) begin
      level <= (q2 > CHAN_MAX) ? 8'hFF : q2[7:0];
    end
  end

endmodule

### design/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter.
//
// Input channel hsv/hsv_valid/hsv_ready carries one HSV word per pixel:
// hue in 1/64 degree (values of 360 degrees or more wrap once), saturation
// and brightness as 8-bit fractions. Output channel rgb/rgb_valid/rgb_ready
// carries one RGB word of 8-bit channels per accepted input word, in order.
// Each word is accepted when valid and ready are both high at a clock edge.
//
// Five register stages: hue reduction and sector pick, chroma mix weights,
// brightness multiply, reciprocal multiply, remainder correction with
// round-up. rgb_valid rises when the word is loaded into the output stage.
// Throughput is one word per clock while rgb_ready stays high.
//
// Each stage keeps its own valid bit; a stage loads whenever it is empty or
// the stage after it moves. When the receiver holds rgb_ready low the pipe
// fills bubbles first, then hsv_ready drops; nothing is lost or repeated.
// Synchronous reset empties all stages; data registers are not reset.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hsv_word_t hsv,
  input  logic      hsv_valid,
  output logic      hsv_ready,
  output rgb_word_t rgb,
  output logic      rgb_valid,
  input  logic      rgb_ready
);

  logic [4:0] vld;   // stage valid bits, vld[4] is the output stage
  logic [4:0] adv;   // stage load enables
  adv_t       chan_adv;

  // Stage 1 registers
  logic [2:0]  sector1;
  logic [11:0] tpos1;
  logic [7:0]  sat1;
  logic [7:0]  val1;
  // Stage 2 registers
  logic [19:0] mix_r2;
  logic [19:0] mix_g2;
  logic [19:0] mix_b2;
  logic [7:0]  val2;

  // Stage 1 logic
  logic [14:0] hue_w;
  logic [2:0]  sector_n;
  logic [14:0] base;
  logic [14:0] fpos;
  logic [11:0] tpos_n;
  // Stage 2 logic
  logic [11:0] w_r;
  logic [11:0] w_g;
  logic [11:0] w_b;
  logic [19:0] gray;

  // Load-enable chain from the output back to the input.
  always_comb begin
    adv[4] = !vld[4] || rgb_ready;
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign hsv_ready   = adv[0];
  assign rgb_valid   = vld[4];
  assign chan_adv.s3 = adv[2];
  assign chan_adv.s4 = adv[3];
  assign chan_adv.s5 = adv[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 5'd0;
    end else begin
      if (adv[0]) vld[0] <= hsv_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
    end
  end

  // Stage 1: wrap hue, find the sector and the position within it.
  always_comb begin
    hue_w = (hsv.hue >= HUE_FULL) ? (hsv.hue - HUE_FULL) : hsv.hue;
    if (hue_w >= 15'd19200)      sector_n = SEC_MAG_RED;
    else if (hue_w >= 15'd15360) sector_n = SEC_BLU_MAG;
    else if (hue_w >= 15'd11520) sector_n = SEC_CYN_BLU;
    else if (hue_w >= 15'd7680)  sector_n = SEC_GRN_CYN;
    else if (hue_w >= 15'd3840)  sector_n = SEC_YEL_GRN;
    else                         sector_n = SEC_RED_YEL;
    base   = 15'(sector_n) * 15'(SECTOR_STEPS);
    fpos   = hue_w - base;
    // Odd sectors run downhill.
    tpos_n = sector_n[0] ? (SECTOR_STEPS - fpos[11:0]) : fpos[11:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sector1 <= sector_n;
      tpos1   <= tpos_n;
      sat1    <= hsv.saturation;
      val1    <= hsv.brightness;
    end
  end

  // Stage 2: route chroma / ramp / zero, then sat*w + (1-sat) share.
  always_comb begin
    unique case (sector1)
      SEC_RED_YEL: begin w_r = SECTOR_STEPS; w_g = tpos1;        w_b = 12'd0;        end
      SEC_YEL_GRN: begin w_r = tpos1;        w_g = SECTOR_STEPS; w_b = 12'd0;        end
      SEC_GRN_CYN: begin w_r = 12'd0;        w_g = SECTOR_STEPS; w_b = tpos1;        end
      SEC_CYN_BLU: begin w_r = 12'd0;        w_g = tpos1;        w_b = SECTOR_STEPS; end
      SEC_BLU_MAG: begin w_r = tpos1;        w_g = 12'd0;        w_b = SECTOR_STEPS; end
      default:     begin w_r = SECTOR_STEPS; w_g = 12'd0;        w_b = tpos1;        end
    endcase
    gray = 20'(FRAC_ONE - sat1) * 20'(SECTOR_STEPS);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      mix_r2 <= 20'(sat1) * 20'(w_r) + gray;
      mix_g2 <= 20'(sat1) * 20'(w_g) + gray;
      mix_b2 <= 20'(sat1) * 20'(w_b) + gray;
      val2   <= val1;
    end
  end

  // Stages 3 to 5, one lane per channel.
  hsvrgb_chan u_red (
    .clk        (clk),
    .adv        (chan_adv),
    .brightness (val2),
    .mix        (mix_r2),
    .level      (rgb.red)
  );

  hsvrgb_chan u_green (
    .clk        (clk),
    .adv        (chan_adv),
    .brightness (val2),
    .mix        (mix_g2),
    .level      (rgb.green)
  );

  hsvrgb_chan u_blue (
    .clk        (clk),
    .adv        (chan_adv),
    .brightness (val2),
    .mix        (mix_b2),
    .level      (rgb.blue)
  );

endmodule

### design/hsvrgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
module hsvrgb_checker
  import hsvrgb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input hsv_word_t hsv,
  input logic      hsv_valid,
  input logic      hsv_ready,
  input rgb_word_t rgb,
  input logic      rgb_valid,
  input logic      rgb_ready
);

  // Stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
    else $error("rgb word changed or dropped while stalled");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rgb_valid)
    else $error("rgb_valid after reset");

  // A receiver that takes words never backs up the input.
  a_flow_through: assert property (@(posedge clk)
    rgb_ready |-> hsv_ready)
    else $error("hsv_ready low while rgb_ready high");

  // Input stalls only when the output is holding a word.
  a_stall_cause: assert property (@(posedge clk)
    !hsv_ready |-> rgb_valid)
    else $error("hsv_ready low with empty output");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
  .clk       (clk),
  .rst       (rst),
  .hsv       (hsv),
  .hsv_valid (hsv_valid),
  .hsv_ready (hsv_ready),
  .rgb       (rgb),
  .rgb_valid (rgb_valid),
  .rgb_ready (rgb_ready)
);

### dv/hsv_to_rgb_checker.sv
// Channel monitor for the HSV to RGB converter: predicts each RGB word and compares it.
`timescale 1ns / 100ps

module hsv_to_rgb_checker
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hsv_word_t hsv,
  input  logic      hsv_valid,
  input  logic      hsv_ready,
  input  rgb_word_t rgb,
  input  logic      rgb_valid,
  input  logic      rgb_ready,
  output int        mismatch_count,
  output int        pending_count
);

  localparam int unsigned CHANNEL_DIV = int'(FRAC_ONE) * int'(SECTOR_STEPS);

  rgb_word_t rgb_expected[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // ceil(val * (sat*w + (255-sat)*3840) / (255*3840)), capped at 255
  function automatic logic [7:0] scale_channel(input logic [7:0] sat, input logic [7:0] val,
                                                input logic [11:0] weight);
    int unsigned s, v, num, quot;
    s    = sat;
    v    = val;
    num  = v * (s * weight + (int'(FRAC_ONE) - s) * int'(SECTOR_STEPS));
    quot = (num + CHANNEL_DIV - 1) / CHANNEL_DIV;
    if (quot > 255) quot = 255;
    return quot[7:0];
  endfunction

  function automatic rgb_word_t predict_rgb(input hsv_word_t px);
    int unsigned h, pos, ramp;
    logic [2:0]  sector;
    logic [11:0] wr, wg, wb;
    rgb_word_t   res;
    h = px.hue;
    if (h >= HUE_FULL) h -= HUE_FULL;   // out-of-range hue wraps once
    sector = 3'(h / SECTOR_STEPS);
    pos    = h % SECTOR_STEPS;
    ramp   = sector[0] ? int'(SECTOR_STEPS) - pos : pos;
    case (sector)
      SEC_RED_YEL: begin wr = SECTOR_STEPS; wg = 12'(ramp);    wb = '0;           end
      SEC_YEL_GRN: begin wr = 12'(ramp);    wg = SECTOR_STEPS; wb = '0;           end
      SEC_GRN_CYN: begin wr = '0;           wg = SECTOR_STEPS; wb = 12'(ramp);    end
      SEC_CYN_BLU: begin wr = '0;           wg = 12'(ramp);    wb = SECTOR_STEPS; end
      SEC_BLU_MAG: begin wr = 12'(ramp);    wg = '0;           wb = SECTOR_STEPS; end
      default:     begin wr = SECTOR_STEPS; wg = '0;           wb = 12'(ramp);    end
    endcase
    res.red   = scale_channel(px.saturation, px.brightness, wr);
    res.green = scale_channel(px.saturation, px.brightness, wg);
    res.blue  = scale_channel(px.saturation, px.brightness, wb);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rgb_word_t want;
    if (rst) begin
      rgb_expected.delete();
      pending_count <= 0;
    end else begin
      if (rgb_valid && rgb_ready) begin
        if (rgb_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected RGB word, expected none, got %h", $time, rgb);
        end else begin
          want = rgb_expected.pop_front();
          check_field("red",   want.red,   rgb.red);
          check_field("green", want.green, rgb.green);
          check_field("blue",  want.blue,  rgb.blue);
        end
      end
      if (hsv_valid && hsv_ready)
        rgb_expected.push_back(predict_rgb(hsv));
      pending_count <= rgb_expected.size();
    end
  end

endmodule

### dv/hsv_to_rgb_converter_test.sv
// Top of the HSV to RGB converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_test
  import hsvrgb_pkg::*;
;

  localparam int RANDOM_WORDS = 1450;
  localparam int QUIET_TAIL   = 200;     // final words with no idling on either side
  localparam int LONG_HOLD    = 60;      // receiver stall, long enough to back up the pipe
  localparam int HOLD_AT_WORD = 500;
  localparam int DRAIN_CYCLES = 20;      // pipe is 5 deep; margin for trailing words
  localparam int CYCLE_LIMIT  = 200000;  // watchdog limit for the whole run
  localparam int DIRECTED     = 22;

  logic      clk;
  logic      rst;
  hsv_word_t hsv;
  logic      hsv_valid;
  logic      hsv_ready;
  rgb_word_t rgb;
  logic      rgb_valid;
  logic      rgb_ready;

  int mismatch_count;
  int pending_count;
  int words_sent = 0;
  int cycle_count = 0;
  bit long_hold_done = 1'b0;

  // Idling is off in the tail and in one window of every 300 words, so
  // back-to-back traffic shows up mid-run too.
  wire quiet = (words_sent >= DIRECTED + RANDOM_WORDS - QUIET_TAIL) ||
               (words_sent % 300 >= 200);

  // Directed words: sector borders, both ends of the hue range, wrapped
  // hue codes, and the extremes of saturation and brightness.
  int unsigned directed_hue[DIRECTED] = '{
    0, 23039, 3840, 3839, 7680, 11520, 15360, 19200, 19199, 23040, 32767,
    26880, 1920, 1920, 1920, 5760, 9600, 13440, 17280, 21120, 1, 7679
  };
  int unsigned directed_sat[DIRECTED] = '{
    255, 255, 255, 255, 255, 255, 255, 255, 200, 255, 255,
    128, 0, 255, 0, 1, 254, 128, 255, 77, 255, 255
  };
  int unsigned directed_val[DIRECTED] = '{
    255, 255, 255, 255, 255, 255, 255, 255, 128, 255, 255,
    200, 255, 0, 0, 1, 254, 255, 128, 191, 255, 255
  };

  hsv_to_rgb_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .hsv       (hsv),
    .hsv_valid (hsv_valid),
    .hsv_ready (hsv_ready),
    .rgb       (rgb),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready)
  );

  hsv_to_rgb_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .hsv            (hsv),
    .hsv_valid      (hsv_valid),
    .hsv_ready      (hsv_ready),
    .rgb            (rgb),
    .rgb_valid      (rgb_valid),
    .rgb_ready      (rgb_ready),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fractions lean on 0 and 255 now and then; the rest is uniform.
  function automatic logic [7:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly legal hue; one in eight spans all 15 bits to hit the wrap path.
  function automatic hsv_word_t random_pixel();
    hsv_word_t px;
    if ($urandom_range(0, 7) == 0)
      px.hue = 15'($urandom);
    else
      px.hue = 15'($urandom_range(0, int'(HUE_FULL) - 1));
    px.saturation = pick_fraction();
    px.brightness = pick_fraction();
    return px;
  endfunction

  // Offer one word and hold it until accepted. A gap, when taken, lowers
  // valid in the step of the previous acceptance and raises it later, so
  // valid never gets two updates in one step.
  task automatic offer_word(input hsv_word_t px);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      hsv_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hsv       <= px;
    hsv_valid <= 1'b1;
    do @(posedge clk); while (!hsv_ready);
    words_sent++;
  endtask

  // Sender side and verdict.
  initial begin
    hsv_word_t px;
    rst       <= 1'b1;
    hsv       <= '0;
    hsv_valid <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED; i++) begin
      px.hue        = 15'(directed_hue[i]);
      px.saturation = 8'(directed_sat[i]);
      px.brightness = 8'(directed_val[i]);
      offer_word(px);
    end
    for (int i = 0; i < RANDOM_WORDS; i++)
      offer_word(random_pixel());
    hsv_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_count != 0)
      $display("%0t ns: %0d RGB words expected but never delivered", $time, pending_count);
    if (mismatch_count == 0 && pending_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Receiver side: random stall bursts, plus one long stall while the
  // sender keeps offering, so the pipe fills and hsv_ready drops.
  initial begin
    rgb_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    rgb_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!long_hold_done && words_sent >= HOLD_AT_WORD) begin
        long_hold_done = 1'b1;
        rgb_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rgb_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rgb_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        rgb_ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached, %0d words still expected", $time, pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
